### rtl/sco_pkg.sv
// Shared types and constants for the server clock offset tracker.
// No dependencies; every other file in rtl/ imports this package.
package sco_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_NUDGE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUDGE_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DRIFT_EN = 3'd5;

  // Reset values of the configuration registers.
  localparam logic signed [10:0] TIME_NUDGE_RST    = 11'sd0;
  localparam logic [9:0]         NUDGE_LIMIT_RST   = 10'd30;
  localparam logic [15:0]        RESET_THRESH_RST  = 16'd500;
  localparam logic [15:0]        FAST_THRESH_RST   = 16'd100;
  localparam logic [9:0]         EXTRAP_MARGIN_RST = 10'd5;
  localparam logic               SLOW_DRIFT_EN_RST = 1'b1;

  typedef enum logic [2:0] {
    ADJ_NONE      = 3'd0,
    ADJ_RESET     = 3'd1,
    ADJ_FAST      = 3'd2,
    ADJ_SLOW_BACK = 3'd3,
    ADJ_SLOW_FWD  = 3'd4,
    ADJ_FIRST     = 3'd5
  } adj_kind_t;

  typedef struct packed {
    logic signed [10:0] time_nudge;
    logic [9:0]         nudge_limit;
    logic [15:0]        reset_threshold;
    logic [15:0]        fast_threshold;
    logic [9:0]         extrapolate_margin;
    logic               slow_drift_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] server_time_est;
    logic signed [TIME_W-1:0] offset_now;
    adj_kind_t                adjust_kind;
    logic                     locked;
    logic                     time_error;
  } result_t;

endpackage

### rtl/sco_cfg.sv
// Configuration register file of the offset tracker.
// Depends on sco_pkg for the register indexes, reset values and cfg_t.
module sco_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [sco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sco_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sco_pkg::cfg_t                     cfg
);
  import sco_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_nudge         <= TIME_NUDGE_RST;
      cfg.nudge_limit        <= NUDGE_LIMIT_RST;
      cfg.reset_threshold    <= RESET_THRESH_RST;
      cfg.fast_threshold     <= FAST_THRESH_RST;
      cfg.extrapolate_margin <= EXTRAP_MARGIN_RST;
      cfg.slow_drift_enable  <= SLOW_DRIFT_EN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TIME_NUDGE:    cfg.time_nudge         <= $signed(cfg_data[10:0]);
        CFG_NUDGE_LIMIT:   cfg.nudge_limit        <= cfg_data[9:0];
        CFG_RESET_THRESH:  cfg.reset_threshold    <= cfg_data;
        CFG_FAST_THRESH:   cfg.fast_threshold     <= cfg_data;
        CFG_EXTRAP_MARGIN: cfg.extrapolate_margin <= cfg_data[9:0];
        CFG_SLOW_DRIFT_EN: cfg.slow_drift_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/sco_core.sv
// Tracking state and per-tick correction logic of the offset tracker.
// Depends on sco_pkg; the state advances only on a cycle where fire is high.
module sco_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic signed [sco_pkg::TIME_W-1:0] local_t,
  input  logic signed [sco_pkg::TIME_W-1:0] snap_t,
  input  logic                              fresh,
  input  sco_pkg::cfg_t                     cfg,
  output sco_pkg::result_t                  res
);
  import sco_pkg::*;

  logic                     is_locked, is_locked_next;
  logic signed [TIME_W-1:0] offset, offset_next;
  logic signed [TIME_W-1:0] last_output_time, last_output_time_next;
  logic signed [TIME_W-1:0] last_snap_time, last_snap_time_next;
  logic                     extrapolated, extrapolated_next;

  logic signed [11:0]       nudge_wide;
  logic signed [11:0]       lim_pos;
  logic signed [11:0]       lim_neg;
  logic signed [11:0]       nudge_sat;
  logic signed [TIME_W-1:0] nudge32;

  logic signed [TIME_W-1:0] target;
  logic signed [TIME_W-1:0] off1;
  logic signed [TIME_W-1:0] lot1;
  logic signed [TIME_W-1:0] sum;
  logic signed [TIME_W-1:0] est_raw;
  logic signed [TIME_W-1:0] est_mono;
  logic signed [TIME_W-1:0] snap_margin;
  logic signed [TIME_W-1:0] gap;
  logic [TIME_W-1:0]        mag;
  logic                     fresh_locked;
  logic                     back_step;
  logic                     ext1;

  // Saturate the signed nudge to plus or minus the limit.
  always_comb begin
    nudge_wide = {cfg.time_nudge[10], cfg.time_nudge};
    lim_pos    = $signed({2'b00, cfg.nudge_limit});
    lim_neg    = -lim_pos;
    if (nudge_wide < lim_neg) begin
      nudge_sat = lim_neg;
    end else if (nudge_wide > lim_pos) begin
      nudge_sat = lim_pos;
    end else begin
      nudge_sat = nudge_wide;
    end
    nudge32 = {{(TIME_W-12){nudge_sat[11]}}, nudge_sat};
  end

  // On the first-lock tick the offset and output floor come from the snapshot.
  assign target       = snap_t - local_t;
  assign off1         = is_locked ? offset : target;
  assign lot1         = is_locked ? last_output_time : snap_t;
  assign fresh_locked = is_locked & fresh;
  assign back_step    = snap_t < last_snap_time;

  assign sum         = local_t + off1;
  assign est_raw     = sum - nudge32;
  assign est_mono    = (est_raw < lot1) ? lot1 : est_raw;
  assign snap_margin = snap_t - $signed({22'd0, cfg.extrapolate_margin});
  assign ext1        = extrapolated | ~(sum < snap_margin);
  assign gap         = target - off1;
  assign mag         = gap[TIME_W-1] ? 32'(-gap) : 32'(gap);

  always_comb begin
    is_locked_next        = is_locked;
    offset_next           = offset;
    last_output_time_next = last_output_time;
    last_snap_time_next   = last_snap_time;
    extrapolated_next     = extrapolated;

    res.server_time_est = '0;
    res.offset_now      = offset;
    res.adjust_kind     = ADJ_NONE;
    res.locked          = 1'b0;
    res.time_error      = 1'b0;

    if (is_locked || fresh) begin
      is_locked_next        = 1'b1;
      offset_next           = off1;
      last_output_time_next = lot1;
      res.adjust_kind       = is_locked ? ADJ_NONE : ADJ_FIRST;
      res.locked            = 1'b1;
      if (back_step) begin
        res.time_error      = 1'b1;
        res.server_time_est = lot1;
      end else begin
        last_snap_time_next   = snap_t;
        last_output_time_next = est_mono;
        res.server_time_est   = est_mono;
        extrapolated_next     = ext1;
        if (fresh_locked) begin
          if (mag > {16'd0, cfg.reset_threshold}) begin
            offset_next           = target;
            last_output_time_next = snap_t;
            res.server_time_est   = snap_t;
            res.adjust_kind       = ADJ_RESET;
          end else if (mag > {16'd0, cfg.fast_threshold}) begin
            offset_next     = off1 + (gap >>> 1);
            res.adjust_kind = ADJ_FAST;
          end else if (cfg.slow_drift_enable) begin
            if (ext1) begin
              extrapolated_next = 1'b0;
              offset_next       = off1 - 32'sd2;
              res.adjust_kind   = ADJ_SLOW_BACK;
            end else begin
              offset_next     = off1 + 32'sd1;
              res.adjust_kind = ADJ_SLOW_FWD;
            end
          end
        end
      end
      res.offset_now = offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_locked        <= 1'b0;
      offset           <= '0;
      last_output_time <= '0;
      last_snap_time   <= '0;
      extrapolated     <= 1'b0;
    end else if (fire) begin
      is_locked        <= is_locked_next;
      offset           <= offset_next;
      last_output_time <= last_output_time_next;
      last_snap_time   <= last_snap_time_next;
      extrapolated     <= extrapolated_next;
    end
  end

endmodule

### rtl/server_clock_offset_tracker.sv
// Server clock offset tracker, top level: input register, core, result register.
// An input transfer is held in the input register, then moves into the result register
// when that is empty or being drained; throughput 1 tick per cycle while out_ready is high,
// set by the update of the offset state between the two registers. Synchronous active-high reset clears the
// tracking state and both registers' valid flags, and loads the configuration defaults.
// Depends on sco_pkg, sco_cfg and sco_core.
module server_clock_offset_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [sco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sco_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sco_pkg::TIME_W-1:0] local_time,
  input  logic signed [sco_pkg::TIME_W-1:0] snap_time,
  input  logic                              new_snapshot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sco_pkg::TIME_W-1:0] server_time_est,
  output logic signed [sco_pkg::TIME_W-1:0] offset_now,
  output logic [2:0]                        adjust_kind,
  output logic                              locked,
  output logic                              time_error
);
  import sco_pkg::*;

  cfg_t                     cfg;
  result_t                  res;
  result_t                  res_q;
  logic                     in_full;
  logic signed [TIME_W-1:0] local_q;
  logic signed [TIME_W-1:0] snap_q;
  logic                     fresh_q;
  logic                     fire;

  // A held item moves on whenever the result register is empty or being drained.
  assign fire     = in_full & (~out_valid | out_ready);
  assign in_ready = ~in_full | fire;

  sco_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sco_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .local_t (local_q),
    .snap_t  (snap_q),
    .fresh   (fresh_q),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      local_q <= local_time;
      snap_q  <= snap_time;
      fresh_q <= new_snapshot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign server_time_est = res_q.server_time_est;
  assign offset_now      = res_q.offset_now;
  assign adjust_kind     = res_q.adjust_kind;
  assign locked          = res_q.locked;
  assign time_error      = res_q.time_error;

endmodule

### rtl/sco_checker.sv
// Port-level checker for the offset tracker, bound onto the top level.
// Depends on sco_pkg for the adjustment codes.
module sco_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sco_pkg::TIME_W-1:0] server_time_est,
  input logic signed [sco_pkg::TIME_W-1:0] offset_now,
  input logic [2:0]                        adjust_kind,
  input logic                              locked,
  input logic                              time_error
);
  import sco_pkg::*;

  // No result may be offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(server_time_est)
      && $stable(offset_now) && $stable(adjust_kind))
    else $error("stalled result changed");

  // An unlocked tick reports nothing but the stored offset.
  a_unlocked_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !locked |-> adjust_kind == ADJ_NONE && !time_error
      && server_time_est == '0)
    else $error("unlocked result carries an estimate or adjustment");

  // A backward snapshot skips every offset correction.
  a_error_no_adjust: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_error |-> locked
      && (adjust_kind == ADJ_NONE || adjust_kind == ADJ_FIRST))
    else $error("offset corrected on a backward snapshot");

endmodule

bind server_clock_offset_tracker sco_checker u_sco_checker (.*);
